### rtl/core/websocket_frame_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define WSFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define WSFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define WSFD_ASSERT_IMP(lbl, ante, cons)
`define WSFD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### rtl/core/wsfd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsfd_pkg;

    // Result kinds.
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Header byte field masks and length escape codes.
    localparam logic [7:0] TOP_BIT_MASK = 8'h80;
    localparam logic [7:0] OPCODE_MASK  = 8'h0F;
    localparam logic [7:0] LEN7_MASK    = 8'h7F;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;

    // Header byte counts at which an extended length field is complete.
    localparam logic [3:0] HDR_LAST_EXT16 = 4'd4;
    localparam logic [3:0] HDR_LAST_EXT64 = 4'd10;

    // One result transaction.
    typedef struct packed {
        logic        result_kind;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        is_masked;
        logic [63:0] frame_len;
        logic [31:0] xor_key;
        logic [3:0]  header_bytes;
        logic [7:0]  data_byte;
        logic        frame_end;
    } wsfd_result_t;

endpackage

### rtl/core/wsfd_if.sv
// Channel interfaces of the deframer: received bytes in, results out.
interface wsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        is_masked;
    logic [63:0] frame_len;
    logic [31:0] xor_key;
    logic [3:0]  header_bytes;
    logic [7:0]  data_byte;
    logic        frame_end;

    modport source (
        output valid, output result_kind, output fin_flag, output frame_opcode,
        output is_masked, output frame_len, output xor_key,
        output header_bytes, output data_byte, output frame_end,
        input ready
    );
    modport sink (
        input valid, input result_kind, input fin_flag, input frame_opcode,
        input is_masked, input frame_len, input xor_key,
        input header_bytes, input data_byte, input frame_end,
        output ready
    );
endinterface

### rtl/core/wsfd_parser.sv
// Frame parse state machine: consumes one byte per step and forms its result.
module wsfd_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            byte_in,
    output logic                  has_result,
    output wsfd_pkg::wsfd_result_t result
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXT16,
        PH_EXT64,
        PH_KEY,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        fin_reg, fin_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  kidx_reg, kidx_next;

    logic [6:0]  len7;
    logic [3:0]  hdr_cnt_inc;
    logic [1:0]  kidx_inc;
    logic [7:0]  key_byte;
    logic        finish;
    logic        payload_hit;
    logic        payload_end;
    logic [3:0]  ext_last;

    assign len7        = byte_in[6:0] & wsfd_pkg::LEN7_MASK[6:0];
    assign hdr_cnt_inc = hdr_cnt_reg + 4'd1;
    assign kidx_inc    = kidx_reg + 2'd1;
    assign ext_last    = (phase_reg == PH_EXT16) ? wsfd_pkg::HDR_LAST_EXT16
                                                 : wsfd_pkg::HDR_LAST_EXT64;
    // Key byte for this payload position; first key byte sits in the top bits.
    assign key_byte    = key_reg[(5'd31 - {kidx_reg, 3'b000}) -: 8];

    // Next-state logic for one byte.
    always_comb
    begin
        phase_next  = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kidx_next   = kidx_reg;
        finish      = 1'b0;
        payload_hit = 1'b0;
        payload_end = 1'b0;

        case (phase_reg)
            PH_FIRST:
            begin
                fin_next     = (byte_in & wsfd_pkg::TOP_BIT_MASK) != 8'd0;
                opcode_next  = byte_in[3:0] & wsfd_pkg::OPCODE_MASK[3:0];
                masked_next  = 1'b0;
                len_next     = '0;
                key_next     = '0;
                remain_next  = '0;
                kidx_next    = '0;
                hdr_cnt_next = 4'd1;
                phase_next   = PH_SECOND;
            end
            PH_SECOND:
            begin
                masked_next  = (byte_in & wsfd_pkg::TOP_BIT_MASK) != 8'd0;
                hdr_cnt_next = 4'd2;
                len_next     = '0;
                if (len7 == wsfd_pkg::LEN_CODE_16)
                begin
                    phase_next = PH_EXT16;
                end
                else if (len7 == wsfd_pkg::LEN_CODE_64)
                begin
                    phase_next = PH_EXT64;
                end
                else
                begin
                    len_next = {57'd0, len7};
                    if (masked_next)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                len_next     = {len_reg[55:0], byte_in};
                hdr_cnt_next = hdr_cnt_inc;
                if (hdr_cnt_inc == ext_last)
                begin
                    if (masked_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            PH_KEY:
            begin
                key_next     = {key_reg[23:0], byte_in};
                kidx_next    = kidx_inc;
                hdr_cnt_next = hdr_cnt_inc;
                if (kidx_inc == 2'd0)
                begin
                    finish = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                payload_hit = 1'b1;
                kidx_next   = kidx_inc;
                remain_next = remain_reg - 64'd1;
                payload_end = (remain_reg == 64'd1);
                if (payload_end)
                begin
                    phase_next = PH_FIRST;
                end
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase

        // Header complete: load the payload counter and choose the next phase.
        if (finish)
        begin
            remain_next = len_next;
            kidx_next   = '0;
            phase_next  = (len_next == 64'd0) ? PH_FIRST : PH_PAYLOAD;
        end
    end

    // Result fields reflect the state after this byte.
    always_comb
    begin
        has_result            = finish || payload_hit;
        result.result_kind    = payload_hit ? wsfd_pkg::KIND_PAYLOAD : wsfd_pkg::KIND_HEADER;
        result.fin_flag       = fin_next;
        result.frame_opcode   = opcode_next;
        result.is_masked      = masked_next;
        result.frame_len      = len_next;
        result.xor_key        = key_next;
        result.header_bytes   = hdr_cnt_next;
        result.data_byte      = payload_hit ? (byte_in ^ key_byte) : 8'd0;
        result.frame_end      = payload_hit ? payload_end : (len_next == 64'd0);
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            hdr_cnt_reg <= '0;
            fin_reg     <= 1'b0;
            opcode_reg  <= '0;
            masked_reg  <= 1'b0;
            len_reg     <= '0;
            key_reg     <= '0;
            remain_reg  <= '0;
            kidx_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            masked_reg  <= masked_next;
            len_reg     <= len_next;
            key_reg     <= key_next;
            remain_reg  <= remain_next;
            kidx_reg    <= kidx_next;
        end
    end

endmodule

### rtl/core/websocket_frame_deframer.sv
// WebSocket frame deframer: one received byte per cycle unless a stalled output blocks it, one result at most per byte.
// A byte accepted into the input register is parsed from there and its result is stored in the result register.
// Throughput: one byte per cycle, through the combinational parse step between the
// input register and the result register; a stalled output holds a byte that has a result.
// Reset: rst_n (asynchronous, active low) returns the parser to the first header
// byte and empties both the input and the result registers.
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
    input  logic          clk,
    input  logic          rst_n,
    wsfd_in_if.sink       rx,
    wsfd_out_if.source    res
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg, out_valid_next;
    wsfd_pkg::wsfd_result_t out_reg;

    logic                  has_result;
    wsfd_pkg::wsfd_result_t step_result;
    logic                  out_free;
    logic                  step;

    // A byte advances unless it has a result and the result register is full and not being read.
    assign out_free = !out_valid_reg || res.ready;
    assign step     = in_valid_reg && (!has_result || out_free);
    assign rx.ready = !in_valid_reg || step;

    wsfd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_in    (in_byte_reg),
        .has_result (has_result),
        .result     (step_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && has_result)
        begin
            out_reg <= step_result;
        end
    end

    // Output transaction fields.
    assign res.valid          = out_valid_reg;
    assign res.result_kind    = out_reg.result_kind;
    assign res.fin_flag       = out_reg.fin_flag;
    assign res.frame_opcode   = out_reg.frame_opcode;
    assign res.is_masked      = out_reg.is_masked;
    assign res.frame_len      = out_reg.frame_len;
    assign res.xor_key        = out_reg.xor_key;
    assign res.header_bytes   = out_reg.header_bytes;
    assign res.data_byte      = out_reg.data_byte;
    assign res.frame_end      = out_reg.frame_end;

    // A byte whose result cannot be stored must block the input side.
    `WSFD_ASSERT_IMP(a_block_on_full, in_valid_reg && has_result && !out_free, !rx.ready)
    // A header result ends the frame exactly when the length is zero.
    `WSFD_ASSERT_IMP(a_hdr_end_len, out_valid_reg && (out_reg.result_kind == wsfd_pkg::KIND_HEADER), out_reg.frame_end == (out_reg.frame_len == 64'd0))
    // An unmasked frame always reports a zero key.
    `WSFD_ASSERT_IMP(a_unmasked_key, out_valid_reg && !out_reg.is_masked, out_reg.xor_key == 32'd0)
    // A stored result is never dropped while the output side stalls.
    `WSFD_ASSERT_NXT(a_result_kept, out_valid_reg && !res.ready, out_valid_reg)

endmodule
